FILE: rtl/core/sitd_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the field widths, the ASCII codes and the shared types.
// No dependencies.
package sitd_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
	localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [BCD_W-1:0]   bcd_t;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Each accepted value passes through serial BCD conversion in sitd_dabble, the load of the
// digits, the minus sign of a negative value, the skip of leading zeros one at a time and the
// exit from the skip, and then the digit characters one at a time; the sign and the digits
// each wait while the output register holds a stalled character. Skipped zeros and digits
// always add up to ten. The conversion loop, one magnitude bit per cycle, takes most of a
// value's time. in_stall drops again in the cycle after the last character enters the output
// register, so the next value is taken while that character still waits for its transfer.
// Depends on sitd_pkg and sitd_dabble.
module signed_int_to_decimal_ascii (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sitd_pkg::value_t value,
	output logic             out_valid,
	input  logic             out_stall,
	output sitd_pkg::char_t  character,
	output logic             last
);
	import sitd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_SKIP = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic              neg_q;
	bcd_t              digit_q;
	logic [LEFT_W-1:0] left_q;
	logic              out_valid_q;
	char_t             char_q;
	logic              last_q;

	logic   in_xfer;
	logic   out_free;
	logic   out_load;
	logic   conv_done;
	bcd_t   conv_bcd;
	value_t mag;
	digit_t top_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (state_q == ST_SIGN || state_q == ST_EMIT);
	assign mag       = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
	assign top_digit = digit_q[BCD_W-1 -: DIGIT_W];

	sitd_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						left_q  <= LEFT_W'(NUM_DIGITS);
						state_q <= neg_q ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == '0 && left_q != LEFT_W'(1)) begin
						left_q <= left_q - LEFT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						left_q <= left_q - LEFT_W'(1);
						if (left_q == LEFT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			neg_q <= value[VALUE_W-1];
		end
		case (state_q)
			ST_CONV: begin
				if (conv_done) begin
					digit_q <= conv_bcd;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					char_q <= ASCII_MINUS;
					last_q <= 1'b0;
				end
			end
			ST_SKIP: begin
				if (top_digit == '0 && left_q != LEFT_W'(1)) begin
					digit_q <= {digit_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					char_q  <= ASCII_ZERO + CHAR_W'(top_digit);
					last_q  <= (left_q == LEFT_W'(1));
					digit_q <= {digit_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

FILE: rtl/core/sitd_dabble.sv
// Bit-serial binary to BCD converter (shift and add three).
// Shifts one magnitude bit per cycle into ten BCD digits.
// Depends on sitd_pkg.
module sitd_dabble (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sitd_pkg::value_t mag,
	output logic            done,
	output sitd_pkg::bcd_t  bcd
);
	import sitd_pkg::*;

	value_t                 bin_q;
	bcd_t                   bcd_q;
	logic [BIT_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	bcd_t                   bcd_adj;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == BIT_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_CNT_W'(VALUE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - BIT_CNT_W'(1);
				if (cnt_q == BIT_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

FILE: rtl/core/sitd_checker.sv
// Port-level checker for signed_int_to_decimal_ascii and the bind that attaches it.
// Watches the handshakes and the character stream over time.
// Depends on sitd_pkg.
module sitd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input sitd_pkg::value_t value,
	input logic             out_valid,
	input logic             out_stall,
	input sitd_pkg::char_t  character,
	input logic             last
);
	import sitd_pkg::*;

	// A stalled result keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled result changed");

	// Only a minus sign or a decimal digit is ever shown.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == ASCII_MINUS) ||
			(character >= ASCII_ZERO && character <= ASCII_NINE))
		else $error("character outside the expected set");

	// The sign never ends a number's text.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == ASCII_MINUS |-> !last)
		else $error("minus sign marked last");

	// A value transfer is followed by a busy period.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a transfer");

	// A stalled value keeps its valid and its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(value))
		else $error("stalled input changed");

endmodule

bind signed_int_to_decimal_ascii sitd_checker u_sitd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.character (character),
	.last      (last)
);

FILE: bench/testbench.sv
// Testbench for signed_int_to_decimal_ascii: directed values, then random ones.
// Each character transfer is checked against typed text or a behavioral conversion.
// Depends on sitd_pkg and the signed_int_to_decimal_ascii RTL.
module testbench;
	import sitd_pkg::*;

	localparam int RANDOM_ITEMS = 300;
	localparam int PAUSE_AT     = 150;
	localparam int QUIET_FROM   = RANDOM_ITEMS - 40;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 80;
	localparam int NUM_ROWS     = 20;

	typedef char_t text_t[$];

	typedef struct packed {
		char_t character;
		logic  last;
	} glyph_t;

	typedef struct {
		value_t value;
		string  text;
	} row_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	value_t value;
	logic   out_valid;
	logic   out_stall;
	char_t  character;
	logic   last;

	glyph_t expected_chars[$];
	string  typed_texts[$];
	int     values_taken = 0;
	int     mismatches = 0;
	int     cycle_count = 0;
	bit     quiet = 1'b0;

	row_t directed_rows [NUM_ROWS] = '{
		'{32'h00000000, "0"},
		'{32'h00000001, "1"},
		'{32'hFFFFFFFF, "-1"},
		'{32'h7FFFFFFF, "2147483647"},
		'{32'h80000000, "-2147483648"},
		'{32'h80000001, "-2147483647"},
		'{32'd9, "9"},
		'{32'd10, "10"},
		'{-32'sd10, ""},
		'{32'd99, ""},
		'{32'd100, ""},
		'{-32'sd5, ""},
		'{32'd999999999, ""},
		'{32'd1000000000, ""},
		'{-32'sd999999999, ""},
		'{-32'sd1000000000, ""},
		'{32'd123456789, ""},
		'{32'h55555555, ""},
		'{32'hAAAAAAAA, ""},
		'{32'd1000000, ""}
	};

	signed_int_to_decimal_ascii dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.character(character),
		.last(last)
	);

	always #10 clk = ~clk;

	function automatic text_t decimal_text(value_t v);
		text_t  t;
		value_t mag;
		mag = v[VALUE_W-1] ? ~v + 1'b1 : v;
		do begin
			t.push_front(ASCII_ZERO + char_t'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (v[VALUE_W-1]) begin
			t.push_front(ASCII_MINUS);
		end
		return t;
	endfunction

	function automatic value_t pick_value();
		value_t      v;
		int unsigned p;
		int unsigned k;
		k = $urandom_range(1, 9);
		p = 1;
		repeat (k) p = p * 10;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(0, 20);
			2: v = p + $urandom_range(0, 2) - 1;
			default: v = $urandom % p;
		endcase
		if ($urandom_range(0, 1)) begin
			v = ~v + 1'b1;
		end
		return v;
	endfunction

	task automatic offer(value_t v, string text);
		typed_texts.push_back(text);
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_input(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		text_t  t;
		string  s;
		glyph_t want;
		if (arst_n && in_valid && !in_stall) begin
			s = typed_texts.pop_front();
			if (s.len() != 0) begin
				t = {};
				for (int j = 0; j < s.len(); j++) t.push_back(char_t'(s[j]));
			end else begin
				t = decimal_text(value);
			end
			foreach (t[i]) expected_chars.push_back(glyph_t'{t[i], i == t.size() - 1});
			values_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual %h last %b", $time,
					character, last);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (want.character !== character) begin
					$display("%0t: character expected %h, actual %h", $time,
						want.character, character);
					mismatches++;
				end
				if (want.last !== last) begin
					$display("%0t: last expected %b, actual %b", $time, want.last, last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		bit long_done;
		long_done = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_done && values_taken >= 30) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				long_done = 1'b1;
				@(posedge clk);
			end else if (!quiet && (cycle_count / 64) % 3 != 0 && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			if ($urandom_range(0, 2) == 0) begin
				pause_input($urandom_range(1, 4));
			end
			offer(directed_rows[i].value, directed_rows[i].text);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= QUIET_FROM);
			if (i == PAUSE_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_chars.size() != 0) @(posedge clk);
			end else if (!quiet && (i / 25) % 3 != 0 && $urandom_range(0, 2) == 0) begin
				pause_input($urandom_range(1, 4));
			end
			offer(pick_value(), "");
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
